/* src/sdt_pkg.sv */
// Package for the squared distance transform unit: defaults, types, control bundles.
`default_nettype none
package sdt_pkg;

    localparam int DEF_MAX_LINE    = 64;
    localparam int DEF_SAMPLE_BITS = 24;
    localparam int IN_W            = 24;
    localparam int DIST_W          = 25;
    localparam int IDX_W           = 6;
    localparam int DEN_W           = 8;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_RV,
        S_MEET,
        S_CMP,
        S_STEP_END,
        S_ORD,
        S_OCHK,
        S_OSMP,
        S_OWAIT
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic ld_in;
        logic rd_top;
        logic ld_v;
        logic ld_meet;
        logic pop;
        logic push;
        logic next_pos;
        logic out_init;
        logic out_rd;
        logic k_inc;
        logic out_ld;
        logic q_inc;
        logic line_clr;
    } t_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic pos_zero;
        logic pop_ok;
        logic adv;
        logic is_end;
        logic q_last;
        logic out_busy;
    } t_status;

endpackage
`default_nettype wire

/* src/sdt_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module sdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* src/sdt_ctrl.sv */
// Controller state machine: envelope build per sample and the output sweep.
`default_nettype none
module sdt_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire sdt_pkg::t_status i_status,
    output sdt_pkg::t_cmd        o_cmd
);
    import sdt_pkg::*;

    t_state r_state, n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.ld_in = 1'b1;
                    n_state = i_status.pos_zero ? S_STEP_END : S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd_top = 1'b1;
                n_state = S_RV;
            end
            S_RV: begin
                o_cmd.ld_v = 1'b1;
                n_state = S_MEET;
            end
            S_MEET: begin
                o_cmd.ld_meet = 1'b1;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_status.pop_ok) begin
                    o_cmd.pop = 1'b1;
                    n_state = S_RD;
                end else begin
                    o_cmd.push = 1'b1;
                    n_state = S_STEP_END;
                end
            end
            S_STEP_END: begin
                if (i_status.is_end) begin
                    o_cmd.out_init = 1'b1;
                    n_state = S_ORD;
                end else begin
                    o_cmd.next_pos = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ORD: begin
                o_cmd.out_rd = 1'b1;
                n_state = S_OCHK;
            end
            S_OCHK: begin
                if (i_status.adv) begin
                    o_cmd.k_inc = 1'b1;
                    n_state = S_ORD;
                end else begin
                    o_cmd.ld_v = 1'b1;
                    n_state = S_OSMP;
                end
            end
            S_OSMP: begin
                o_cmd.out_ld = 1'b1;
                n_state = S_OWAIT;
            end
            S_OWAIT: begin
                if (!i_status.out_busy) begin
                    if (i_status.q_last) begin
                        o_cmd.line_clr = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.q_inc = 1'b1;
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* src/sdt_dpath.sv */
// Datapath: sample/vertex/boundary stores, intersection math, output register.
`default_nettype none
module sdt_dpath #(
    parameter int MAX_LINE    = sdt_pkg::DEF_MAX_LINE,
    parameter int SAMPLE_BITS = sdt_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire sdt_pkg::t_cmd               i_cmd,
    output sdt_pkg::t_status                 o_status,
    input  wire logic [sdt_pkg::IN_W-1:0]    i_sample,
    input  wire logic                        i_last,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [sdt_pkg::DIST_W-1:0]       o_distance,
    output logic [sdt_pkg::IDX_W-1:0]        o_nearest_index,
    output logic                             o_end_of_line
);
    import sdt_pkg::*;

    localparam int AW = (MAX_LINE > 1) ? $clog2(MAX_LINE) : 1;
    localparam int SB = SAMPLE_BITS;
    localparam int FW = (SB > 12) ? SB : 12;
    localparam int NW = FW + 2;
    localparam int PW = NW + DEN_W + 1;
    localparam int DW = AW + 2;
    localparam int SW = 34;

    // Control-ish registers
    logic [AW-1:0] r_pos, r_top, r_k, r_q;
    logic          r_end, r_out_valid;
    // Payload registers
    logic [SB-1:0]           r_fq;
    logic [AW-1:0]           r_v;
    logic signed [NW-1:0]    r_num, r_bnum;
    logic [DEN_W-1:0]        r_den, r_bden;
    logic [DIST_W-1:0]       r_dist;
    logic [AW-1:0]           r_idx;
    logic                    r_eol;

    // RAM ports
    logic [SB-1:0]     samp_rdata;
    logic [AW-1:0]     vert_rdata, vert_waddr, vert_wdata, vert_raddr, bnd_raddr, top_inc;
    logic              vert_we;
    logic [NW-1:0]     bnum_rdata;
    logic [DEN_W-1:0]  bden_rdata;
    logic [31:0]       in_ext;
    logic [SB-1:0]     f_in;

    assign in_ext  = 32'(i_sample);
    assign f_in    = in_ext[SB-1:0];
    assign top_inc = r_top + AW'(1);

    assign vert_we    = (i_cmd.ld_in && (r_pos == '0)) || i_cmd.push;
    assign vert_waddr = i_cmd.push ? top_inc : '0;
    assign vert_wdata = i_cmd.push ? r_pos : '0;
    assign vert_raddr = i_cmd.out_rd ? r_k : r_top;
    assign bnd_raddr  = i_cmd.out_rd ? (r_k + AW'(1)) : r_top;

    sdt_ram #(.WIDTH(SB), .DEPTH(MAX_LINE), .AW(AW)) u_samp (
        .i_clk, .i_we(i_cmd.ld_in), .i_waddr(r_pos), .i_wdata(f_in),
        .i_raddr(vert_rdata), .o_rdata(samp_rdata)
    );
    sdt_ram #(.WIDTH(AW), .DEPTH(MAX_LINE), .AW(AW)) u_vert (
        .i_clk, .i_we(vert_we), .i_waddr(vert_waddr), .i_wdata(vert_wdata),
        .i_raddr(vert_raddr), .o_rdata(vert_rdata)
    );
    sdt_ram #(.WIDTH(NW), .DEPTH(MAX_LINE), .AW(AW)) u_bnum (
        .i_clk, .i_we(i_cmd.push), .i_waddr(top_inc), .i_wdata(r_num),
        .i_raddr(bnd_raddr), .o_rdata(bnum_rdata)
    );
    sdt_ram #(.WIDTH(DEN_W), .DEPTH(MAX_LINE), .AW(AW)) u_bden (
        .i_clk, .i_we(i_cmd.push), .i_waddr(top_inc), .i_wdata(r_den),
        .i_raddr(bnd_raddr), .o_rdata(bden_rdata)
    );

    // Intersection of the new parabola with the one rooted at r_v
    logic signed [NW-1:0]  meet_num;
    logic [DEN_W-1:0]      meet_den;
    logic [AW-1:0]         pos_m_v;
    logic [2*AW-1:0]       pos_sq, v_sq;
    assign pos_sq   = {{AW{1'b0}}, r_pos} * {{AW{1'b0}}, r_pos};
    assign v_sq     = {{AW{1'b0}}, r_v} * {{AW{1'b0}}, r_v};
    assign pos_m_v  = r_pos - r_v;
    assign meet_num = $signed(NW'(r_fq)) + $signed(NW'(pos_sq))
                    - $signed(NW'(samp_rdata)) - $signed(NW'(v_sq));
    assign meet_den = DEN_W'({pos_m_v, 1'b0});

    // Pop test by cross-multiplication: num/den <= bnum/bden
    logic signed [PW-1:0] prod_l, prod_r, prod_q;
    assign prod_l = PW'(r_num) * PW'($signed({1'b0, r_bden}));
    assign prod_r = PW'(r_bnum) * PW'($signed({1'b0, r_den}));
    // Output sweep: boundary strictly below q
    assign prod_q = PW'($signed({1'b0, r_q})) * PW'($signed({1'b0, bden_rdata}));

    // Distance for position q from vertex v
    logic signed [DW-1:0]   dq;
    logic signed [2*DW-1:0] dq2;
    logic [SW-1:0]          dsum;
    assign dq   = $signed(DW'(r_q)) - $signed(DW'(r_v));
    assign dq2  = dq * dq;
    assign dsum = SW'($unsigned(dq2)) + SW'(samp_rdata);

    assign o_status.pos_zero = (r_pos == '0);
    assign o_status.pop_ok   = (r_top != '0) && (prod_l <= prod_r);
    assign o_status.adv      = (r_k != r_top) && (PW'($signed(bnum_rdata)) < prod_q);
    assign o_status.is_end   = r_end;
    assign o_status.q_last   = (r_q == r_pos);
    assign o_status.out_busy = r_out_valid;

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.ld_in && (r_pos == '0)) r_top <= '0;
            if (i_cmd.pop)      r_top <= r_top - AW'(1);
            if (i_cmd.push)     r_top <= top_inc;
            if (i_cmd.next_pos) r_pos <= r_pos + AW'(1);
            if (i_cmd.line_clr) begin
                r_pos <= '0;
                r_top <= '0;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_in) begin
            r_fq  <= f_in;
            r_end <= i_last || (r_pos == AW'(MAX_LINE - 1));
        end
        if (i_cmd.ld_v) begin
            r_v    <= vert_rdata;
            r_bnum <= $signed(bnum_rdata);
            r_bden <= bden_rdata;
        end
        if (i_cmd.ld_meet) begin
            r_num <= meet_num;
            r_den <= meet_den;
        end
        if (i_cmd.out_init) begin
            r_k <= '0;
            r_q <= '0;
        end
        if (i_cmd.k_inc) r_k <= r_k + AW'(1);
        if (i_cmd.q_inc) r_q <= r_q + AW'(1);
        if (i_cmd.out_ld) begin
            r_dist <= dsum[DIST_W-1:0];
            r_idx  <= r_v;
            r_eol  <= (r_q == r_pos);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_distance      = r_dist;
    assign o_nearest_index = IDX_W'(r_idx);
    assign o_end_of_line   = r_eol;

endmodule
`default_nettype wire

/* src/squared_distance_transform_1d_unit.sv */
// Usage:
// One line of cost samples enters on the input channel (i_valid/o_ready), one
// transaction per position, i_last on the final sample. A line of MAX_LINE
// samples ends on its own. Each sample is folded into the lower envelope of
// parabolas at once; except for the first sample this runs a read, intersect,
// cross-multiply loop over the boundary store, once more for each envelope
// vertex the sample pops. Pops total at most one per sample over a line.
// After the final sample the block sends one result transaction per position,
// in increasing order, on o_valid/i_ready; o_end_of_line marks the last one.
// The next result is prepared only once the previous one is taken, stepping over
// any envelope boundaries crossed; results wait in the output register.
// No sample is taken while results of a line are being sent.
// Reset (i_rst_n low at a clock edge) empties the line; the stores need no
// clearing, entries are only read after being written in the current line.
`default_nettype none
module squared_distance_transform_1d_unit #(
    parameter int MAX_LINE    = sdt_pkg::DEF_MAX_LINE,
    parameter int SAMPLE_BITS = sdt_pkg::DEF_SAMPLE_BITS
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [sdt_pkg::IN_W-1:0]    i_sample,
    input  wire logic                        i_last,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [sdt_pkg::DIST_W-1:0]       o_distance,
    output logic [sdt_pkg::IDX_W-1:0]        o_nearest_index,
    output logic                             o_end_of_line
);
    import sdt_pkg::*;

    t_cmd    cmd;
    t_status status;

    sdt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_status(status), .o_cmd(cmd)
    );

    sdt_dpath #(.MAX_LINE(MAX_LINE), .SAMPLE_BITS(SAMPLE_BITS)) u_dpath (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_status(status),
        .i_sample, .i_last,
        .o_valid, .i_ready,
        .o_distance, .o_nearest_index, .o_end_of_line
    );

endmodule
`default_nettype wire

/* src/sdt_checker.sv */
// Port-level checker for the squared distance transform unit, with its bind.
`default_nettype none
module sdt_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_ready,
    input wire logic        o_valid,
    input wire logic        i_ready,
    input wire logic [24:0] o_distance,
    input wire logic [5:0]  o_nearest_index,
    input wire logic        o_end_of_line
);

    // Stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance)
            && $stable(o_nearest_index) && $stable(o_end_of_line))
        else $error("stalled result changed");

    // No sample is taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ready && o_valid))
        else $error("input ready while result pending");

    // A taken result that is not the end of line does not reopen the input straight away
    a_line_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready && !o_end_of_line |=> !o_ready)
        else $error("input reopened mid-line");

endmodule

bind squared_distance_transform_1d_unit sdt_checker u_sdt_checker (
    .i_clk, .i_rst_n, .o_ready, .o_valid, .i_ready,
    .o_distance, .o_nearest_index, .o_end_of_line
);
`default_nettype wire
